/* rtl/core/gsm7_pkg.sv */
// ----------------------------------------------------------------------------
// gsm7_pkg
// Shared types, septet codes and the ASCII to GSM-7 default alphabet map.
// ----------------------------------------------------------------------------
package gsm7_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SeptetW = 7;
  localparam int unsigned OctetW  = 8;
  // Widest request: seven pending bits, escape septet and one septet
  localparam int unsigned QueueW  = 24;
  localparam int unsigned CountW  = 5;
  localparam int unsigned PendCntW = 3;
  localparam int unsigned NumW    = 2;

  localparam logic [SeptetW-1:0] ESC_SEPTET = 7'h1B;
  localparam logic [SeptetW-1:0] CR_SEPTET  = 7'h0D;
  localparam logic [SeptetW-1:0] AT_SEPTET  = 7'h00;

  typedef struct packed {
    logic               unmapped;
    logic               ext;
    logic [SeptetW-1:0] septet;
  } map_t;

  typedef struct packed {
    logic [QueueW-1:0]   octets;
    logic [NumW-1:0]     num;
    logic                last;
    logic                subst;
    logic [SeptetW-1:0]  pend_bits;
    logic [PendCntW-1:0] pend_cnt;
  } pack_t;

  // Map one ASCII byte to its septet, flag extension and unmapped bytes
  function automatic map_t map_char(input logic [CharW-1:0] c);
    map_t m;
    m.unmapped = 1'b0;
    m.ext      = 1'b0;
    m.septet   = c[SeptetW-1:0];
    case (c)
      8'h40: m.septet = 7'h00;
      8'h24: m.septet = 7'h02;
      8'h0A: m.septet = 7'h0A;
      8'h5F: m.septet = 7'h11;
      8'h5E: begin m.ext = 1'b1; m.septet = 7'h14; end
      8'h7B: begin m.ext = 1'b1; m.septet = 7'h28; end
      8'h7D: begin m.ext = 1'b1; m.septet = 7'h29; end
      8'h5C: begin m.ext = 1'b1; m.septet = 7'h2F; end
      8'h5B: begin m.ext = 1'b1; m.septet = 7'h3C; end
      8'h7E: begin m.ext = 1'b1; m.septet = 7'h3D; end
      8'h5D: begin m.ext = 1'b1; m.septet = 7'h3E; end
      8'h7C: begin m.ext = 1'b1; m.septet = 7'h40; end
      default: begin
        if (!(c inside {[8'h20:8'h23], [8'h25:8'h3F], [8'h41:8'h5A], [8'h61:8'h7A]})) begin
          m.unmapped = 1'b1;
          m.septet   = AT_SEPTET;
        end
      end
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/gsm7_pack.sv */
// ----------------------------------------------------------------------------
// gsm7_pack
// Combinational packer: maps one character and merges its septets with the
// pending bits into up to three octets, plus the next pending state.
// ----------------------------------------------------------------------------
module gsm7_pack (
  input  logic [gsm7_pkg::CharW-1:0]    ascii_char,
  input  logic                          end_of_message,
  input  logic [gsm7_pkg::SeptetW-1:0]  pend_bits,
  input  logic [gsm7_pkg::PendCntW-1:0] pend_cnt,
  output gsm7_pkg::pack_t               pack
);
  import gsm7_pkg::*;

  map_t              m;
  logic [QueueW-1:0] queue;
  logic [QueueW-1:0] tail;
  logic [CountW-1:0] cnt;
  logic [NumW-1:0]   nfull;
  logic [2:0]        rem;
  logic [CountW-1:0] base;

  always_comb begin
    m     = map_char(ascii_char);
    queue = QueueW'(pend_bits);
    cnt   = CountW'(pend_cnt);

    // Prefix extension characters with the escape septet
    if (m.ext) begin
      queue = queue | (QueueW'(ESC_SEPTET) << cnt);
      cnt   = cnt + CountW'(SeptetW);
    end
    queue = queue | (QueueW'(m.septet) << cnt);
    cnt   = cnt + CountW'(SeptetW);

    nfull = cnt[4:3];
    rem   = cnt[2:0];
    base  = {1'b0, nfull, 2'b00} << 1;

    // Fill the spare bits with CR when a single bit is left at message end
    if (end_of_message && rem == 3'd1) begin
      queue = queue | ((QueueW'(CR_SEPTET) << 1) << base);
    end
    tail = queue >> base;

    pack.octets = queue;
    pack.num    = nfull + NumW'(end_of_message && rem != 3'd0);
    pack.last   = end_of_message;
    pack.subst  = m.unmapped;
    if (end_of_message) begin
      pack.pend_bits = '0;
      pack.pend_cnt  = '0;
    end else begin
      pack.pend_bits = tail[SeptetW-1:0];
      pack.pend_cnt  = rem;
    end
  end

endmodule

/* rtl/core/gsm7_septet_packer_core.sv */
// ----------------------------------------------------------------------------
// gsm7_septet_packer_core
// GSM-7 default alphabet septet packer with stream ports.
// ----------------------------------------------------------------------------
// One ASCII character enters per request, in_tlast marking the message end.
// A character is taken into an input register, then mapped and packed into
// up to three octets held in an output buffer, which sends one octet per
// cycle while out_tready is high. While each character yields at most one
// octet and the receiver is ready, a new request is accepted every cycle; a
// character yielding 2 or 3 octets holds back the next one until its octets
// have left the single-octet output port. out_tuser flags an unmapped
// character sent as '@'; out_tlast marks the final octet.
module gsm7_septet_packer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ascii_char
  input  logic       in_tlast,   // end_of_message
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] octet
  output logic       out_tlast,  // last_octet
  output logic       out_tuser   // char_substituted
);
  import gsm7_pkg::*;

  logic                s1_valid_r;
  logic [CharW-1:0]    s1_char_r;
  logic                s1_eom_r;
  logic [SeptetW-1:0]  pend_bits_r;
  logic [PendCntW-1:0] pend_cnt_r;
  logic [QueueW-1:0]   buf_data_r;
  logic [NumW-1:0]     buf_cnt_r;
  logic                buf_last_r;
  logic                buf_subst_r;

  pack_t pk;
  logic  pop;
  logic  buf_free;
  logic  load;

  gsm7_pack u_pack (
    .ascii_char     (s1_char_r),
    .end_of_message (s1_eom_r),
    .pend_bits      (pend_bits_r),
    .pend_cnt       (pend_cnt_r),
    .pack           (pk)
  );

  // Handshake: buffer is free when empty or its final octet leaves now
  assign pop       = out_tvalid && out_tready;
  assign buf_free  = (buf_cnt_r == '0) || (buf_cnt_r == NumW'(1) && out_tready);
  assign load      = s1_valid_r && buf_free;
  assign in_tready = !s1_valid_r || load;

  assign out_tvalid = (buf_cnt_r != '0);
  assign out_tdata  = buf_data_r[OctetW-1:0];
  assign out_tlast  = buf_last_r && (buf_cnt_r == NumW'(1));
  assign out_tuser  = buf_subst_r;

  // Input register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (load) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Input register: payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_char_r <= in_tdata;
      s1_eom_r  <= in_tlast;
    end
  end

  // Pending bits and octet count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      buf_cnt_r   <= '0;
    end else if (load) begin
      pend_bits_r <= pk.pend_bits;
      pend_cnt_r  <= pk.pend_cnt;
      buf_cnt_r   <= pk.num;
    end else if (pop) begin
      buf_cnt_r   <= buf_cnt_r - NumW'(1);
    end
  end

  // Output buffer: load packed octets, advance one octet per pop
  always_ff @(posedge clk) begin
    if (load) begin
      buf_data_r  <= pk.octets;
      buf_last_r  <= pk.last;
      buf_subst_r <= pk.subst;
    end else if (pop) begin
      buf_data_r  <= buf_data_r >> OctetW;
    end
  end

endmodule

/* rtl/core/gsm7_checker.sv */
// ----------------------------------------------------------------------------
// gsm7_checker
// Port-level checks for the septet packer, bound to the top level.
// ----------------------------------------------------------------------------
module gsm7_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // Drop all pending octets on reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // With nothing to send the block must take a request
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output is empty");

  // Hold a waiting input request
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast))
    else $error("input request changed while waiting");

  // Hold a stalled octet
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output octet changed while stalled");

  // Hold flags of a stalled octet
  a_flag_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tlast) && $stable(out_tuser))
    else $error("output flags changed while stalled");

endmodule

bind gsm7_septet_packer_core gsm7_checker u_gsm7_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

/* tb/gsm7_septet_packer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsm7_septet_packer_core_tb
// Self-checking bench for the GSM-7 septet packer. Messages of ASCII bytes go
// in through the input stream, with bursts and gaps on the sender and a
// changing stall pattern on the receiver. A local model maps each character,
// packs the septets into octets and queues the octets it expects; the monitor
// checks every octet leaving the block against the oldest of them.
// ----------------------------------------------------------------------------
module gsm7_septet_packer_core_tb;

  localparam logic [6:0] ESC_SEPT = 7'h1B;
  localparam logic [6:0] CR_CODE  = 7'h0D;
  localparam logic [6:0] AT_CODE  = 7'h00;
  localparam int unsigned RANDOM_CHARS = 185;

  // Extension-table characters, each sent as escape plus one septet
  localparam logic [7:0] EXT_CHARS [8] = '{8'h5E, 8'h7B, 8'h7D, 8'h5C,
                                           8'h5B, 8'h7E, 8'h5D, 8'h7C};

  typedef enum logic [1:0] {
    CLS_PLAIN,
    CLS_EXT,
    CLS_BAD
  } char_class_t;

  typedef struct {
    char_class_t kind;
    logic [6:0]  septet;
  } gsm_code_t;

  typedef struct {
    logic [7:0] ch;
    logic       eom;
    logic       drain;  // hold this character until all octets are out
  } msg_char_t;

  typedef struct {
    logic [7:0] octet;
    logic       last;
    logic       subst;
  } octet_exp_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] ascii_char
  logic       in_tlast   = 1'b0;   // end_of_message
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] octet
  logic       out_tlast;           // last_octet
  logic       out_tuser;           // char_substituted

  msg_char_t  char_q[$];
  octet_exp_t octet_q[$];

  // Packer state of the local model
  logic [6:0] pend_bits = '0;
  logic [2:0] pend_cnt  = '0;

  int unsigned err_count  = 0;
  int unsigned burst_left = 4;
  int unsigned gap_left   = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned stall_mode = 0;

  gsm7_septet_packer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Map one ASCII byte onto the default alphabet or its extension table
  function automatic gsm_code_t ascii_to_septet(input logic [7:0] ch);
    gsm_code_t r;
    r.kind   = CLS_PLAIN;
    r.septet = ch[6:0];
    case (ch)
      8'h40: r.septet = 7'h00;
      8'h24: r.septet = 7'h02;
      8'h0A: r.septet = 7'h0A;
      8'h5F: r.septet = 7'h11;
      8'h5E: begin r.kind = CLS_EXT; r.septet = 7'h14; end
      8'h7B: begin r.kind = CLS_EXT; r.septet = 7'h28; end
      8'h7D: begin r.kind = CLS_EXT; r.septet = 7'h29; end
      8'h5C: begin r.kind = CLS_EXT; r.septet = 7'h2F; end
      8'h5B: begin r.kind = CLS_EXT; r.septet = 7'h3C; end
      8'h7E: begin r.kind = CLS_EXT; r.septet = 7'h3D; end
      8'h5D: begin r.kind = CLS_EXT; r.septet = 7'h3E; end
      8'h7C: begin r.kind = CLS_EXT; r.septet = 7'h40; end
      default: begin
        if (!((ch >= 8'h20 && ch <= 8'h23) || (ch >= 8'h25 && ch <= 8'h3F) ||
              (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A))) begin
          r.kind   = CLS_BAD;
          r.septet = AT_CODE;
        end
      end
    endcase
    return r;
  endfunction

  // Pack one accepted character and queue the octets it completes
  function automatic void pack_char(input logic [7:0] ch, input logic eom);
    gsm_code_t   cd;
    logic [23:0] acc;
    int unsigned nb;
    int unsigned made;
    octet_exp_t  res [3];
    cd   = ascii_to_septet(ch);
    acc  = {17'd0, pend_bits};
    nb   = pend_cnt;
    made = 0;
    if (cd.kind == CLS_EXT) begin
      acc |= 24'(ESC_SEPT) << nb;
      nb += 7;
    end
    acc |= 24'(cd.septet) << nb;
    nb += 7;
    while (nb >= 8) begin
      res[made] = '{acc[7:0], 1'b0, cd.kind == CLS_BAD};
      made++;
      acc >>= 8;
      nb -= 8;
    end
    if (eom) begin
      // fill a lone leftover bit with CR so the spare septet is not read as '@'
      if (nb == 1) acc |= 24'(CR_CODE) << 1;
      if (nb > 0) begin
        res[made] = '{acc[7:0], 1'b0, cd.kind == CLS_BAD};
        made++;
      end
      if (made > 0) res[made-1].last = 1'b1;
      acc = '0;
      nb  = 0;
    end
    for (int unsigned i = 0; i < made; i++) octet_q.insert(octet_q.size(), res[i]);
    pend_bits = acc[6:0];
    pend_cnt  = 3'(nb);
  endfunction

  // Draw a random character, weighted toward mapped text
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 72) return EXT_CHARS[$urandom_range(0, 7)];
    if (r < 84) begin
      case ($urandom_range(0, 3))
        0: return 8'h40;
        1: return 8'h24;
        2: return 8'h0A;
        default: return 8'h5F;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Driver: present queued characters in bursts, predict on each accept
  always @(posedge clk) begin
    logic       nxt_valid;
    logic [7:0] nxt_data;
    logic       nxt_last;
    msg_char_t  it;
    nxt_valid = in_tvalid;
    nxt_data  = in_tdata;
    nxt_last  = in_tlast;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pack_char(in_tdata, in_tlast);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (char_q.size() > 0 && !(char_q[0].drain && octet_q.size() > 0)) begin
          it        = char_q.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = it.ch;
          nxt_last  = it.eom;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // long bursts give stretches with no idling at all
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap_left   = $urandom_range(0, 6);
          end
        end
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata  <= nxt_data;
    in_tlast  <= nxt_last;
  end

  // Monitor: stall on a changing pattern and check each accepted octet
  always @(posedge clk) begin
    octet_exp_t want;
    logic       rdy;
    cycle_cnt++;
    if (cycle_cnt % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       rdy = 1'b1;
      1:       rdy = 1'($urandom_range(0, 1));
      2:       rdy = (cycle_cnt % 4 == 0);
      default: rdy = ($urandom_range(0, 7) != 0);
    endcase
    if (rst_n && out_tvalid && out_tready) begin
      if (octet_q.size() == 0) begin
        $display("%0t: octet %02h with none expected", $time, out_tdata);
        err_count++;
      end else begin
        want = octet_q.pop_front();
        if (out_tdata !== want.octet) begin
          $display("%0t: octet expected %02h actual %02h", $time, want.octet, out_tdata);
          err_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last_octet expected %0b actual %0b", $time, want.last, out_tlast);
          err_count++;
        end
        if (out_tuser !== want.subst) begin
          $display("%0t: char_substituted expected %0b actual %0b", $time, want.subst,
                   out_tuser);
          err_count++;
        end
      end
    end
    out_tready <= rst_n ? rdy : 1'b0;
  end

  // Stimulus and end of run
  initial begin
    logic [7:0]  directed [25];
    logic        dir_eom  [25];
    msg_char_t   mc;
    int unsigned total;
    int unsigned len;
    int unsigned msg_idx;
    // seven plain septets leave one bit, so the flush adds CR
    directed = '{8'h40, 8'h24, 8'h0A, 8'h5F, 8'h20, 8'h23, 8'h25,
                 8'h5E, 8'h7B, 8'h7D, 8'h5C, 8'h5B, 8'h7E, 8'h5D, 8'h7C,
                 8'hFF,
                 8'h3F, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'h00, 8'h60, 8'h7F, 8'h80};
    // sixteen septets end on a full octet; a lone unmapped byte flushes alone
    dir_eom  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                 1'b1,
                 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    for (int i = 0; i < 25; i++) begin
      mc = '{directed[i], dir_eom[i], 1'b0};
      char_q.insert(char_q.size(), mc);
    end

    total   = 0;
    msg_idx = 0;
    while (total < RANDOM_CHARS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      if (len > RANDOM_CHARS - total) len = RANDOM_CHARS - total;
      for (int unsigned k = 0; k < len; k++) begin
        mc = '{pick_char(), k == len - 1,
               k == 0 && (msg_idx == 0 || $urandom_range(0, 4) == 0)};
        char_q.insert(char_q.size(), mc);
      end
      total += len;
      msg_idx++;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (char_q.size() > 0 || in_tvalid) @(posedge clk);
    while (octet_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
